FILE: hdl/ptwvr_pkg.sv
// Package for the peer table worst-value replacement unit.
// Holds the sizes, codes, payload structs and controller types shared by all modules.
// Depends on nothing.
package ptwvr_pkg;

   localparam int TABLE_SLOTS = 8;
   localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam int ID_W = 32;
   localparam int VAL_W = 32;
   localparam int MM_W = 4;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [VAL_W-1:0] COUNT_CEILING = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MEMBERS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ELIG_TICKS = CSR_IDX_W'(1);

   localparam logic [MM_W-1:0] MAX_MEMBERS_RESET = MM_W'(8);
   localparam logic [VAL_W-1:0] ELIG_TICKS_RESET = VAL_W'(60);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_INC    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_TICK   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_EXISTS   = 3'd0,
      ST_INSERTED = 3'd1,
      ST_REPLACED = 3'd2,
      ST_FULL     = 3'd3,
      ST_DONE     = 3'd4
   } status_type;

   typedef struct packed {
      opcode_type opcode;
      logic [ID_W-1:0] peer_id;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [ID_W-1:0] evicted_id;
      logic evicted_valid;
      logic table_full;
   } rsp_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_SCAN,
      CS_DRAIN,
      CS_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic commit;
   } cmd_type;

endpackage

FILE: hdl/ptwvr_controller.sv
// Controller state machine of the peer table unit.
// Sequences the slot scan and the commit step; uses ptwvr_pkg.
module ptwvr_controller
   import ptwvr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic [SLOT_W-1:0] addr_ff, addr_in;
   logic last_slot;

   assign last_slot = (addr_ff == SLOT_W'(TABLE_SLOTS - 1));

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;
      case (state_ff)
         CS_IDLE: begin
            addr_in = '0;
            if (start) begin
               state_in = CS_SCAN;
            end
         end
         CS_SCAN: begin
            if (last_slot) begin
               state_in = CS_DRAIN;
            end else begin
               addr_in = addr_ff + SLOT_W'(1);
            end
         end
         CS_DRAIN: begin
            state_in = CS_COMMIT;
         end
         CS_COMMIT: begin
            state_in = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_comb begin
      busy = 1'b1;
      cmd = '0;
      cmd.rd_addr = addr_ff;
      case (state_ff)
         CS_IDLE: begin
            busy = 1'b0;
            cmd.load = start;
         end
         CS_SCAN: begin
            cmd.rd_en = 1'b1;
         end
         CS_DRAIN: begin
         end
         CS_COMMIT: begin
            cmd.commit = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
      end
   end

endmodule

FILE: hdl/ptwvr_datapath.sv
// Datapath of the peer table unit: configuration registers, slot memories,
// scan accumulators and the commit logic; uses ptwvr_pkg.
module ptwvr_datapath
   import ptwvr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req,
   input  cmd_type               cmd,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output rsp_type               rsp,
   output logic                  rsp_valid
);

   logic [MM_W-1:0] max_members_ff;
   logic [VAL_W-1:0] elig_ticks_ff;
   logic [VAL_W-1:0] countdown_ff;

   logic [ID_W-1:0] peer_mem [TABLE_SLOTS];
   logic [VAL_W-1:0] cnt_mem [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0] used_ff, used_in;
   logic [TABLE_SLOTS-1:0] cv_ff, cv_in;

   req_type req_ff;
   logic rd_valid_ff;
   logic [SLOT_W-1:0] rd_idx_ff;
   logic [ID_W-1:0] peer_rd_ff;
   logic [VAL_W-1:0] cnt_rd_ff;

   logic [CNT_W-1:0] members_ff;
   logic found_ff;
   logic [SLOT_W-1:0] match_idx_ff;
   logic [VAL_W-1:0] match_cnt_ff;
   logic free_found_ff;
   logic [SLOT_W-1:0] free_idx_ff;
   logic worst_found_ff;
   logic [SLOT_W-1:0] worst_idx_ff;
   logic [ID_W-1:0] worst_peer_ff;
   logic [VAL_W-1:0] best_ff;

   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff;

   logic [VAL_W-1:0] cnt_eff;
   logic slot_hit;
   logic [CNT_W-1:0] limit;
   logic full_before;
   logic [CNT_W-1:0] new_members;
   logic place_en, clr_en, inc_en, clear_all, tick_en;
   logic [SLOT_W-1:0] place_idx, clr_idx;

   // The count memory holds stale data for slots whose valid bit is clear.
   assign cnt_eff = cv_ff[rd_idx_ff] ? cnt_rd_ff : '0;
   assign slot_hit = used_ff[rd_idx_ff] && (peer_rd_ff == req_ff.peer_id);

   always_comb begin
      if (max_members_ff == '0) begin
         limit = CNT_W'(1);
      end else if (32'(max_members_ff) > 32'(TABLE_SLOTS)) begin
         limit = CNT_W'(TABLE_SLOTS);
      end else begin
         limit = CNT_W'(max_members_ff);
      end
   end

   assign full_before = (members_ff >= limit);

   always_comb begin
      place_en = 1'b0;
      place_idx = free_idx_ff;
      clr_en = 1'b0;
      clr_idx = match_idx_ff;
      inc_en = 1'b0;
      clear_all = 1'b0;
      tick_en = 1'b0;
      new_members = members_ff;
      rsp_in.status = ST_DONE;
      rsp_in.evicted_id = '0;
      rsp_in.evicted_valid = 1'b0;
      case (req_ff.opcode)
         OP_INSERT: begin
            if (found_ff) begin
               rsp_in.status = ST_EXISTS;
            end else if (!full_before) begin
               place_en = 1'b1;
               new_members = members_ff + CNT_W'(1);
               clear_all = (new_members >= limit);
               rsp_in.status = ST_INSERTED;
            end else if (countdown_ff != '0) begin
               rsp_in.status = ST_FULL;
            end else begin
               clr_en = 1'b1;
               clr_idx = worst_idx_ff;
               place_en = 1'b1;
               if (!(free_found_ff && (free_idx_ff < worst_idx_ff))) begin
                  place_idx = worst_idx_ff;
               end
               clear_all = 1'b1;
               rsp_in.evicted_id = worst_peer_ff;
               rsp_in.evicted_valid = 1'b1;
               rsp_in.status = ST_REPLACED;
            end
         end
         OP_INC: begin
            inc_en = full_before && found_ff && (match_cnt_ff != COUNT_CEILING);
         end
         OP_REMOVE: begin
            if (found_ff) begin
               clr_en = 1'b1;
               new_members = members_ff - CNT_W'(1);
               rsp_in.evicted_id = req_ff.peer_id;
               rsp_in.evicted_valid = 1'b1;
            end
         end
         OP_TICK: begin
            tick_en = 1'b1;
         end
         default: begin
         end
      endcase
      rsp_in.table_full = (new_members >= limit);
   end

   always_comb begin
      used_in = used_ff;
      cv_in = cv_ff;
      if (clr_en) begin
         used_in[clr_idx] = 1'b0;
         cv_in[clr_idx] = 1'b0;
      end
      if (place_en) begin
         used_in[place_idx] = 1'b1;
         cv_in[place_idx] = 1'b0;
      end
      if (inc_en) begin
         cv_in[match_idx_ff] = 1'b1;
      end
      if (clear_all) begin
         cv_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         peer_rd_ff <= peer_mem[cmd.rd_addr];
         cnt_rd_ff <= cnt_mem[cmd.rd_addr];
      end
      if (cmd.commit && place_en) begin
         peer_mem[place_idx] <= req_ff.peer_id;
      end
      if (cmd.commit && inc_en) begin
         cnt_mem[match_idx_ff] <= match_cnt_ff + VAL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= cmd.rd_addr;
      if (cmd.load) begin
         req_ff <= req;
         found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         worst_found_ff <= 1'b0;
         best_ff <= COUNT_CEILING;
         members_ff <= '0;
      end else if (rd_valid_ff) begin
         if (used_ff[rd_idx_ff]) begin
            members_ff <= members_ff + CNT_W'(1);
            if (!found_ff && slot_hit) begin
               found_ff <= 1'b1;
               match_idx_ff <= rd_idx_ff;
               match_cnt_ff <= cnt_eff;
            end
            if (cnt_eff <= best_ff) begin
               best_ff <= cnt_eff;
               worst_found_ff <= 1'b1;
               worst_idx_ff <= rd_idx_ff;
               worst_peer_ff <= peer_rd_ff;
            end
         end else if (!free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_members_ff <= MAX_MEMBERS_RESET;
         elig_ticks_ff <= ELIG_TICKS_RESET;
         countdown_ff <= '0;
         used_ff <= '0;
         cv_ff <= '0;
         rd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_en;
         rsp_valid_ff <= cmd.commit;
         if (csr_we && (csr_index == CSR_MAX_MEMBERS)) begin
            max_members_ff <= csr_data[MM_W-1:0];
         end
         if (csr_we && (csr_index == CSR_ELIG_TICKS)) begin
            elig_ticks_ff <= csr_data[VAL_W-1:0];
         end
         if (cmd.commit) begin
            used_ff <= used_in;
            cv_ff <= cv_in;
            if (clear_all) begin
               countdown_ff <= elig_ticks_ff;
            end else if (tick_en && (countdown_ff != '0)) begin
               countdown_ff <= countdown_ff - VAL_W'(1);
            end
         end
      end
   end

   assign rsp = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) cmd.commit |=> rsp_valid_ff)
      else $error("Result strobe did not follow the commit step.");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (members_ff > CNT_W'(TABLE_SLOTS))) |-> 1'b0)
      else $error("Scan counted more members than the table has slots.");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (req_ff.opcode == OP_INSERT) && !found_ff && !full_before)
      |-> free_found_ff)
      else $error("Insert into a table that is not full found no free slot.");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (req_ff.opcode == OP_INSERT) && !found_ff && full_before
       && (countdown_ff == '0)) |-> worst_found_ff)
      else $error("Replacement found no member to evict.");
`endif

endmodule

FILE: hdl/peer_table_worst_value_replacement_unit.sv
// Top level of the peer table worst-value replacement unit.
// Instantiates ptwvr_controller and ptwvr_datapath; uses ptwvr_pkg.
//
// Every transaction scans all TABLE_SLOTS slots one per cycle through the single read
// port of the peer and counter memories, then drains the last read in CS_DRAIN and
// commits in CS_COMMIT. The result strobe is registered from the commit step, and busy
// is low in that strobe cycle, so the next transaction can be accepted at the edge that
// ends it. Each result appears for exactly one cycle on rsp_strobe and cannot be stalled.
// There is no clearing pass after reset, and configuration writes are always taken at
// once; they should only be made while no transaction is in flight.
module peer_table_worst_value_replacement_unit
   import ptwvr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type cmd;

   assign csr_ready = 1'b1;

   ptwvr_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   ptwvr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp       (rsp_data),
      .rsp_valid (rsp_strobe)
   );

endmodule

FILE: verif/peer_table_worst_value_replacement_unit_tb.sv
// Self-checking testbench for peer_table_worst_value_replacement_unit.
// Runs a directed script, then randomized phases under several register settings, against an
// in-file predictor of the peer table. Depends on ptwvr_pkg and the unit's RTL.
module peer_table_worst_value_replacement_unit_tb
   import ptwvr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      RK_PREDICTED,
      RK_KNOWN,
      RK_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      opcode_type opcode;
      logic [CSR_IDX_W-1:0] index;
      logic [31:0] word;
      rsp_type known;
   } script_row_type;

   localparam rsp_type NO_RSP = '{ST_DONE, 32'h0, 1'b0, 1'b0};
   localparam int STALL_LIMIT = 40 * (TABLE_SLOTS + 3);

   localparam script_row_type SCRIPT [0:33] = '{
      '{RK_CSR, OP_INSERT, CSR_MAX_MEMBERS, 32'hABCD_EF03, NO_RSP},
      '{RK_CSR, OP_INSERT, CSR_ELIG_TICKS, 32'h0000_0002, NO_RSP},
      '{RK_CSR, OP_INSERT, 8'd2, 32'h0000_0001, NO_RSP},
      '{RK_CSR, OP_INSERT, 8'hFF, 32'hFFFF_FFFF, NO_RSP},
      '{RK_KNOWN, OP_INSERT, 8'd0, 32'h0000_0000, '{ST_INSERTED, 32'h0, 1'b0, 1'b0}},
      '{RK_KNOWN, OP_INSERT, 8'd0, 32'hFFFF_FFFF, '{ST_INSERTED, 32'h0, 1'b0, 1'b0}},
      '{RK_KNOWN, OP_INSERT, 8'd0, 32'h0000_0000, '{ST_EXISTS, 32'h0, 1'b0, 1'b0}},
      '{RK_KNOWN, OP_INC, 8'd0, 32'hFFFF_FFFF, '{ST_DONE, 32'h0, 1'b0, 1'b0}},
      '{RK_KNOWN, OP_REMOVE, 8'd0, 32'h1234_5678, '{ST_DONE, 32'h0, 1'b0, 1'b0}},
      '{RK_KNOWN, OP_INSERT, 8'd0, 32'hA5A5_A5A5, '{ST_INSERTED, 32'h0, 1'b0, 1'b1}},
      '{RK_KNOWN, OP_INSERT, 8'd0, 32'h5A5A_5A5A, '{ST_FULL, 32'h0, 1'b0, 1'b1}},
      '{RK_KNOWN, OP_INC, 8'd0, 32'hFFFF_FFFF, '{ST_DONE, 32'h0, 1'b0, 1'b1}},
      '{RK_KNOWN, OP_INC, 8'd0, 32'h0000_0000, '{ST_DONE, 32'h0, 1'b0, 1'b1}},
      '{RK_KNOWN, OP_INC, 8'd0, 32'h7777_7777, '{ST_DONE, 32'h0, 1'b0, 1'b1}},
      '{RK_KNOWN, OP_TICK, 8'd0, 32'hFFFF_FFFF, '{ST_DONE, 32'h0, 1'b0, 1'b1}},
      '{RK_KNOWN, OP_INSERT, 8'd0, 32'h5A5A_5A5A, '{ST_FULL, 32'h0, 1'b0, 1'b1}},
      '{RK_KNOWN, OP_TICK, 8'd0, 32'h0000_0000, '{ST_DONE, 32'h0, 1'b0, 1'b1}},
      '{RK_KNOWN, OP_TICK, 8'd0, 32'h0000_0000, '{ST_DONE, 32'h0, 1'b0, 1'b1}},
      '{RK_KNOWN, OP_INSERT, 8'd0, 32'h5A5A_5A5A, '{ST_REPLACED, 32'hA5A5_A5A5, 1'b1, 1'b1}},
      '{RK_KNOWN, OP_TICK, 8'd0, 32'h0000_0000, '{ST_DONE, 32'h0, 1'b0, 1'b1}},
      '{RK_PREDICTED, OP_TICK, 8'd0, 32'h0000_0000, NO_RSP},
      '{RK_KNOWN, OP_INSERT, 8'd0, 32'h2222_2222, '{ST_REPLACED, 32'h5A5A_5A5A, 1'b1, 1'b1}},
      '{RK_KNOWN, OP_REMOVE, 8'd0, 32'h0000_0000, '{ST_DONE, 32'h0, 1'b1, 1'b0}},
      '{RK_KNOWN, OP_INSERT, 8'd0, 32'h3333_3333, '{ST_INSERTED, 32'h0, 1'b0, 1'b1}},
      '{RK_KNOWN, OP_REMOVE, 8'd0, 32'hFFFF_FFFF, '{ST_DONE, 32'hFFFF_FFFF, 1'b1, 1'b0}},
      '{RK_CSR, OP_INSERT, CSR_MAX_MEMBERS, 32'hFFFF_FFF0, NO_RSP},
      '{RK_CSR, OP_INSERT, CSR_ELIG_TICKS, 32'h0000_0000, NO_RSP},
      '{RK_KNOWN, OP_TICK, 8'd0, 32'h0000_0000, '{ST_DONE, 32'h0, 1'b0, 1'b1}},
      '{RK_PREDICTED, OP_TICK, 8'd0, 32'h0000_0000, NO_RSP},
      '{RK_PREDICTED, OP_INSERT, 8'd0, 32'h4444_4444, NO_RSP},
      '{RK_PREDICTED, OP_INSERT, 8'd0, 32'h5555_5555, NO_RSP},
      '{RK_CSR, OP_INSERT, CSR_MAX_MEMBERS, 32'h0000_000F, NO_RSP},
      '{RK_CSR, OP_INSERT, CSR_ELIG_TICKS, 32'hFFFF_FFFF, NO_RSP},
      '{RK_PREDICTED, OP_INSERT, 8'd0, 32'h6666_6666, NO_RSP}
   };

   localparam int PHASES = 7;
   localparam logic [MM_W-1:0] PHASE_LIMIT [PHASES] = '{4'd8, 4'd2, 4'd15, 4'd0, 4'd5, 4'd1, 4'd8};
   localparam logic [VAL_W-1:0] PHASE_TICKS [PHASES] =
      '{32'd3, 32'd0, 32'd5, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'd60};
   localparam int PHASE_ITEMS [PHASES] = '{150, 130, 150, 120, 100, 100, 250};
   localparam int PHASE_IDLE [PHASES] = '{20, 10, 30, 0, 25, 15, 0};

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   logic member_used [TABLE_SLOTS];
   logic [ID_W-1:0] member_id [TABLE_SLOTS];
   logic [VAL_W-1:0] member_score [TABLE_SLOTS];
   logic [VAL_W-1:0] grace_left;
   logic [MM_W-1:0] limit_reg;
   logic [VAL_W-1:0] grace_reg;

   rsp_type outcomes_due [$];
   int mismatches = 0;
   int results_seen = 0;
   int stall_cycles = 0;

   peer_table_worst_value_replacement_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int occupancy();
      int n;
      n = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (member_used[i]) n++;
      end
      return n;
   endfunction

   function automatic bit at_limit();
      int lim;
      lim = int'(limit_reg);
      if (lim < 1) lim = 1;
      if (lim > TABLE_SLOTS) lim = TABLE_SLOTS;
      return occupancy() >= lim;
   endfunction

   function automatic int slot_of(logic [ID_W-1:0] id);
      int s;
      s = -1;
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
         if (member_used[i] && member_id[i] == id) s = i;
      end
      return s;
   endfunction

   function automatic void admit(logic [ID_W-1:0] id);
      int s;
      s = -1;
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
         if (!member_used[i]) s = i;
      end
      if (s >= 0) begin
         member_used[s] = 1'b1;
         member_id[s] = id;
         member_score[s] = '0;
      end
      if (at_limit()) begin
         for (int i = 0; i < TABLE_SLOTS; i++) member_score[i] = '0;
         grace_left = grace_reg;
      end
   endfunction

   function automatic logic [ID_W-1:0] drop_lowest();
      int worst;
      logic [VAL_W-1:0] lowest;
      worst = -1;
      lowest = COUNT_CEILING;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (member_used[i] && member_score[i] <= lowest) begin
            lowest = member_score[i];
            worst = i;
         end
      end
      if (worst < 0) return '0;
      member_used[worst] = 1'b0;
      member_score[worst] = '0;
      return member_id[worst];
   endfunction

   function automatic rsp_type apply_peer_op(req_type r);
      rsp_type o;
      int s;
      o = NO_RSP;
      case (r.opcode)
         OP_INSERT: begin
            if (slot_of(r.peer_id) >= 0) begin
               o.status = ST_EXISTS;
            end else if (!at_limit()) begin
               admit(r.peer_id);
               o.status = ST_INSERTED;
            end else if (grace_left != '0) begin
               o.status = ST_FULL;
            end else begin
               o.evicted_id = drop_lowest();
               o.evicted_valid = 1'b1;
               admit(r.peer_id);
               o.status = ST_REPLACED;
            end
         end
         OP_INC: begin
            if (at_limit()) begin
               s = slot_of(r.peer_id);
               if (s >= 0 && member_score[s] != COUNT_CEILING) member_score[s]++;
            end
         end
         OP_REMOVE: begin
            s = slot_of(r.peer_id);
            if (s >= 0) begin
               member_used[s] = 1'b0;
               member_score[s] = '0;
               o.evicted_id = r.peer_id;
               o.evicted_valid = 1'b1;
            end
         end
         default: begin
            if (grace_left != '0) grace_left--;
         end
      endcase
      o.table_full = at_limit();
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("%0t ns: result %0d %s: got %0h, expected %0h", $time, results_seen, what,
               got, want);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      while (outcomes_due.size() != 0) @(posedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MAX_MEMBERS) begin
         limit_reg = val[MM_W-1:0];
      end else if (idx == CSR_ELIG_TICKS) begin
         grace_reg = val;
      end
   endtask

   task automatic issue_op(input req_type r, input bit use_known, input rsp_type known,
                           input int idle_rate);
      int idle_left;
      rsp_type predicted;
      idle_left = 0;
      req_data <= r;
      if (idle_rate != 0 && $urandom_range(99) < idle_rate) begin
         idle_left = $urandom_range(4, 1);
         start <= 1'b0;
      end else begin
         start <= 1'b1;
      end
      forever begin
         @(posedge clock);
         if (idle_left != 0) begin
            idle_left--;
            if (idle_left == 0) start <= 1'b1;
         end else if (!busy) begin
            break;
         end else if (idle_rate != 0 && $urandom_range(99) < idle_rate) begin
            idle_left = $urandom_range(4, 1);
            start <= 1'b0;
         end
      end
      predicted = apply_peer_op(r);
      outcomes_due.push_back(use_known ? known : predicted);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (outcomes_due.size() == 0) begin
            report_mismatch("result with no transaction outstanding", 32'(rsp_data.status),
                            '0);
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.evicted_id !== want.evicted_id)
               report_mismatch("evicted_id", rsp_data.evicted_id, want.evicted_id);
            if (rsp_data.evicted_valid !== want.evicted_valid)
               report_mismatch("evicted_valid", 32'(rsp_data.evicted_valid),
                               32'(want.evicted_valid));
            if (rsp_data.table_full !== want.table_full)
               report_mismatch("table_full", 32'(rsp_data.table_full), 32'(want.table_full));
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      req_type op_item;
      logic [ID_W-1:0] id_pool [12];
      logic [CSR_DATA_W-1:0] limit_word;
      int pick;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         member_used[i] = 1'b0;
         member_id[i] = '0;
         member_score[i] = '0;
      end
      grace_left = '0;
      limit_reg = MAX_MEMBERS_RESET;
      grace_reg = ELIG_TICKS_RESET;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < 12; i++) id_pool[i] = $urandom;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(SCRIPT); i++) begin
         if (SCRIPT[i].kind == RK_CSR) begin
            start <= 1'b0;
            write_csr(SCRIPT[i].index, SCRIPT[i].word);
         end else begin
            csr_valid <= 1'b0;
            op_item.opcode = SCRIPT[i].opcode;
            op_item.peer_id = SCRIPT[i].word;
            issue_op(op_item, SCRIPT[i].kind == RK_KNOWN, SCRIPT[i].known, 20);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         start <= 1'b0;
         limit_word = $urandom;
         limit_word[MM_W-1:0] = PHASE_LIMIT[p];
         write_csr(CSR_MAX_MEMBERS, limit_word);
         write_csr(CSR_ELIG_TICKS, PHASE_TICKS[p]);
         csr_valid <= 1'b0;
         for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
            pick = $urandom_range(99);
            if (pick < 35) op_item.opcode = OP_INSERT;
            else if (pick < 65) op_item.opcode = OP_INC;
            else if (pick < 77) op_item.opcode = OP_REMOVE;
            else op_item.opcode = OP_TICK;
            op_item.peer_id = ($urandom_range(4) == 0) ? $urandom : id_pool[$urandom_range(11)];
            issue_op(op_item, 1'b0, NO_RSP, PHASE_IDLE[p]);
         end
      end
      start <= 1'b0;

      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (2 * (TABLE_SLOTS + 3)) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
